@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// shared assertion macros for the waypoint follower rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while reset is high
`define MWF_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, skipped while reset is high
`define MWF_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ hdl/mwf_pkg.sv @@
// ----------------------------------------------------------------------------
// mwf_pkg
// constants, codes and helper functions of the mecanum waypoint follower
// ----------------------------------------------------------------------------
package mwf_pkg;

   localparam int MAX_WAYPOINTS_DEF = 128;
   localparam int ROTATE_ITER_DEF   = 16;

   // operation codes
   localparam logic [1:0] OP_TICK     = 2'd0;
   localparam logic [1:0] OP_REPORT   = 2'd1;
   localparam logic [1:0] OP_WP_WRITE = 2'd2;
   localparam logic [1:0] OP_MANUAL   = 2'd3;

   // register indexes
   localparam logic [2:0] REG_POINT_COUNT   = 3'd0;
   localparam logic [2:0] REG_MAX_SPEED     = 3'd1;
   localparam logic [2:0] REG_MAX_WHEEL_RPM = 3'd2;
   localparam logic [2:0] REG_WHEEL_GAIN    = 3'd3;
   localparam logic [2:0] REG_ARM_SUM       = 3'd4;

   // register reset values
   localparam logic [7:0]  POINT_COUNT_RST   = 8'd100;
   localparam logic [19:0] MAX_SPEED_RST     = 20'd65536;
   localparam logic [14:0] MAX_WHEEL_RPM_RST = 15'd3000;
   localparam logic [19:0] WHEEL_GAIN_RST    = 20'd38400;
   localparam logic [19:0] ARM_SUM_RST       = 20'd32768;

   localparam logic [9:0]  MS_PER_S    = 10'd1000;
   localparam logic [16:0] CORDIC_COMP = 17'd39797;

   typedef logic signed [15:0] rpm_type;

   // atan(2^-i) in 2^-32 turn units
   function automatic logic [31:0] cordic_angle(input logic [4:0] i);
      logic [31:0] a;
      case (i)
         5'd0:  a = 32'h20000000;
         5'd1:  a = 32'h12E4051D;
         5'd2:  a = 32'h09FB385B;
         5'd3:  a = 32'h051111D4;
         5'd4:  a = 32'h028B0D43;
         5'd5:  a = 32'h0145D7E1;
         5'd6:  a = 32'h00A2F61E;
         5'd7:  a = 32'h00517C55;
         5'd8:  a = 32'h0028BE53;
         5'd9:  a = 32'h00145F2E;
         5'd10: a = 32'h000A2F98;
         5'd11: a = 32'h000517CC;
         5'd12: a = 32'h00028BE6;
         5'd13: a = 32'h000145F3;
         5'd14: a = 32'h0000A2F9;
         5'd15: a = 32'h0000517C;
         5'd16: a = 32'h000028BE;
         5'd17: a = 32'h0000145F;
         5'd18: a = 32'h00000A2F;
         5'd19: a = 32'h00000517;
         5'd20: a = 32'h0000028B;
         5'd21: a = 32'h00000145;
         5'd22: a = 32'h000000A2;
         5'd23: a = 32'h00000051;
         default: a = 32'h0;
      endcase
      return a;
   endfunction

   // scale by 2^-24 toward zero, then saturate to +-lim
   function automatic rpm_type wheel_clamp(input logic signed [53:0] p,
                                           input logic [14:0] lim);
      logic signed [54:0] adj;
      logic signed [54:0] r;
      logic signed [54:0] lim_s;
      rpm_type res;
      adj   = 55'(p) + ((p < 0) ? 55'sd16777215 : 55'sd0);
      r     = adj >>> 24;
      lim_s = 55'({40'd0, lim});
      if (r > lim_s) begin
         res = 16'(lim_s);
      end else if (r < -lim_s) begin
         res = 16'(-lim_s);
      end else begin
         res = 16'(r);
      end
      return res;
   endfunction

endpackage

@@ hdl/mecanum_waypoint_follower.sv @@
// ----------------------------------------------------------------------------
// mecanum_waypoint_follower
// waypoint table with nearest-point search, travel timer and mecanum wheel
// kinematics; manual velocity commands bypass the path logic
// ----------------------------------------------------------------------------
//  channel  ports            direction  transfer when
//  request  req_*            in         req_valid & !req_stall
//  result   rsp_*            out        rsp_valid & !rsp_stall
//  config   csr_* (apb)      in/out     psel & penable & pwrite & pready
//
//  tick and waypoint write give no result
//  manual command: lw product, then four wheels on one multiplier
//  fired report: per waypoint read/square/compare, 25 square-root steps, up to three
//  48-bit divides on the shared divider, ROTATE_ITERATIONS cordic steps, wheels
//  reset is synchronous and needs no clearing pass; req_stall is high while busy
//  a finished result waits in the output register until rsp_stall drops
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mecanum_waypoint_follower #(
   parameter int MAX_WAYPOINTS     = mwf_pkg::MAX_WAYPOINTS_DEF,
   parameter int ROTATE_ITERATIONS = mwf_pkg::ROTATE_ITER_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // request channel
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_op,
   input  logic signed [23:0]  req_pos_x,
   input  logic signed [23:0]  req_pos_y,
   input  logic signed [15:0]  req_heading,
   input  logic [6:0]          req_wp_index,
   input  logic signed [23:0]  req_wp_x,
   input  logic signed [23:0]  req_wp_y,
   input  logic signed [23:0]  req_cmd_vx,
   input  logic signed [23:0]  req_cmd_vy,
   input  logic signed [23:0]  req_cmd_turn,
   // result channel
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mwf_pkg::rpm_type    rsp_wheel_one,
   output mwf_pkg::rpm_type    rsp_wheel_two,
   output mwf_pkg::rpm_type    rsp_wheel_three,
   output mwf_pkg::rpm_type    rsp_wheel_four,
   output logic [6:0]          rsp_target_index,
   output logic                rsp_path_done,
   // configuration port
   input  logic                csr_psel,
   input  logic                csr_penable,
   input  logic                csr_pwrite,
   input  logic [4:0]          csr_paddr,
   input  logic [31:0]         csr_pwdata,
   output logic [31:0]         csr_prdata,
   output logic                csr_pready
);
   import mwf_pkg::*;

   localparam int AW    = (MAX_WAYPOINTS > 2) ? $clog2(MAX_WAYPOINTS) : 1;
   localparam int N_CAP = (MAX_WAYPOINTS < 128) ? MAX_WAYPOINTS : 128;
   localparam logic [7:0] N_CAP_V  = 8'(N_CAP);
   localparam logic [4:0] ROT_LAST = 5'(ROTATE_ITERATIONS - 1);

   // sequencer states
   localparam logic [4:0] S_IDLE     = 5'd0;
   localparam logic [4:0] S_SCAN_RD  = 5'd1;
   localparam logic [4:0] S_SCAN_SQ  = 5'd2;
   localparam logic [4:0] S_SCAN_CMP = 5'd3;
   localparam logic [4:0] S_TGT_RD   = 5'd4;
   localparam logic [4:0] S_TGT_SQ   = 5'd5;
   localparam logic [4:0] S_TGT_SUM  = 5'd6;
   localparam logic [4:0] S_SQRT     = 5'd7;
   localparam logic [4:0] S_DL_SET   = 5'd8;
   localparam logic [4:0] S_DIV      = 5'd9;
   localparam logic [4:0] S_DL_END   = 5'd10;
   localparam logic [4:0] S_VX_END   = 5'd11;
   localparam logic [4:0] S_VY_END   = 5'd12;
   localparam logic [4:0] S_ROT_INIT = 5'd13;
   localparam logic [4:0] S_ROT_STEP = 5'd14;
   localparam logic [4:0] S_ROT_MX   = 5'd15;
   localparam logic [4:0] S_ROT_MY   = 5'd16;
   localparam logic [4:0] S_ROT_END  = 5'd17;
   localparam logic [4:0] S_WH_LW    = 5'd18;
   localparam logic [4:0] S_WH_MUL   = 5'd19;
   localparam logic [4:0] S_WH_CLP   = 5'd20;
   localparam logic [4:0] S_OUT      = 5'd21;

   // ---------------------------------------------------------------- config
   logic [7:0]  point_count_ff;
   logic [19:0] max_speed_ff;
   logic [14:0] max_wheel_rpm_ff;
   logic [19:0] wheel_gain_ff;
   logic [19:0] arm_sum_ff;
   logic        csr_we;

   assign csr_pready = 1'b1;
   assign csr_we     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff   <= POINT_COUNT_RST;
         max_speed_ff     <= MAX_SPEED_RST;
         max_wheel_rpm_ff <= MAX_WHEEL_RPM_RST;
         wheel_gain_ff    <= WHEEL_GAIN_RST;
         arm_sum_ff       <= ARM_SUM_RST;
      end else if (csr_we) begin
         case (csr_paddr[4:2])
            REG_POINT_COUNT:   point_count_ff   <= csr_pwdata[7:0];
            REG_MAX_SPEED:     max_speed_ff     <= csr_pwdata[19:0];
            REG_MAX_WHEEL_RPM: max_wheel_rpm_ff <= csr_pwdata[14:0];
            REG_WHEEL_GAIN:    wheel_gain_ff    <= csr_pwdata[19:0];
            REG_ARM_SUM:       arm_sum_ff       <= csr_pwdata[19:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[4:2])
         REG_POINT_COUNT:   csr_prdata = {24'd0, point_count_ff};
         REG_MAX_SPEED:     csr_prdata = {12'd0, max_speed_ff};
         REG_MAX_WHEEL_RPM: csr_prdata = {17'd0, max_wheel_rpm_ff};
         REG_WHEEL_GAIN:    csr_prdata = {12'd0, wheel_gain_ff};
         REG_ARM_SUM:       csr_prdata = {12'd0, arm_sum_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   // ---------------------------------------------------------------- state
   logic [4:0]  state_ff, state_in;
   logic [4:0]  ret_ff;          // state to resume after a divide
   logic [6:0]  target_slot_ff;
   logic [31:0] elapsed_ff;
   logic [31:0] deadline_ff;
   logic        timer_running_ff;
   logic        first_report_ff;

   // latched request
   logic signed [23:0] px_ff, py_ff;
   logic [15:0]        heading_ff;

   // scan
   logic [6:0]  scan_idx_ff;
   logic        found_ff;
   logic [49:0] best_ff;
   logic [48:0] sqx_ff, sqy_ff;
   logic signed [24:0] dx_ff, dy_ff;

   // square root
   logic [49:0] sq_rem_ff;
   logic [50:0] sq_res_ff;
   logic [4:0]  sq_k_ff;

   // shared divider
   logic [47:0] div_num_ff;
   logic [25:0] div_den_ff;
   logic [25:0] div_rem_ff;
   logic [5:0]  div_cnt_ff;

   // rotation
   logic signed [33:0] rx_ff, ry_ff, rz_ff;
   logic [4:0]         rot_i_ff;
   logic signed [51:0] rprod_ff;

   // wheel kinematics
   logic signed [25:0] vx_ff, vy_ff, w_ff;
   logic signed [30:0] lw_ff;
   logic [1:0]         wh_k_ff;
   logic signed [53:0] wprod_ff;
   rpm_type            wres_ff [4];
   logic               done_ff;

   // output register
   logic        rsp_valid_ff;
   rpm_type     rsp_wheel_ff [4];
   logic [6:0]  rsp_target_ff;
   logic        rsp_done_ff;

   // ---------------------------------------------------------------- waypoint memory
   // x in the upper half, y in the lower; writes only while idle, and the read data is
   // used only while busy, so a write never meets a read whose data is used
   logic [47:0]   wp_mem [MAX_WAYPOINTS];
   logic [47:0]   rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          accept;
   logic          wp_we;

   assign accept  = req_valid & ~req_stall;
   assign wp_we   = accept && (req_op == OP_WP_WRITE) &&
                    ({25'd0, req_wp_index} < MAX_WAYPOINTS);
   assign rd_addr = (state_ff == S_SCAN_RD) ? AW'(scan_idx_ff) : AW'(target_slot_ff);

   always_ff @(posedge clock) begin
      if (wp_we) begin
         wp_mem[AW'(req_wp_index)] <= {req_wp_x, req_wp_y};
      end
      rd_data_ff <= wp_mem[rd_addr];
   end

   // ---------------------------------------------------------------- datapath helpers
   logic [7:0]  n_eff, n_last;
   logic        fire, path_end;
   logic signed [24:0] ex, ey;
   logic signed [49:0] ex_sq, ey_sq;
   logic [49:0] sq_sum;
   logic [6:0]  next_tgt;
   logic [50:0] sq_bit, sq_trial;
   logic [26:0] div_t;
   logic        div_ge;
   logic [24:0] mag_x, mag_y;
   logic [31:0] z_raw;
   logic        pre_rot;
   logic signed [33:0] sx, sy, ang;
   logic signed [46:0] lw_prod;
   logic signed [47:0] lw_adj;
   logic signed [32:0] s_wheel;
   logic signed [32:0] vx_e, vy_e, lw_e;

   always_comb begin
      n_eff = (point_count_ff == 8'd0) ? 8'd1 : point_count_ff;
      if (n_eff > N_CAP_V) begin
         n_eff = N_CAP_V;
      end
   end
   assign n_last   = n_eff - 8'd1;
   assign fire     = first_report_ff | (timer_running_ff & (elapsed_ff >= deadline_ff));
   assign path_end = {1'b0, target_slot_ff} >= n_last;

   // offset from the latched position to the waypoint just read
   assign ex     = 25'(signed'(rd_data_ff[47:24])) - 25'(px_ff);
   assign ey     = 25'(signed'(rd_data_ff[23:0])) - 25'(py_ff);
   assign ex_sq  = ex * ex;
   assign ey_sq  = ey * ey;
   assign sq_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign next_tgt = ({1'b0, scan_idx_ff} + 8'd1 > n_last) ? n_last[6:0] : scan_idx_ff + 7'd1;

   // one square-root bit per cycle
   assign sq_bit   = 51'd1 << {sq_k_ff, 1'b0};
   assign sq_trial = sq_res_ff + sq_bit;

   // restoring divide, one quotient bit per cycle
   assign div_t  = {div_rem_ff, div_num_ff[47]};
   assign div_ge = div_t >= {1'b0, div_den_ff};

   assign mag_x = dx_ff[24] ? 25'(-dx_ff) : 25'(dx_ff);
   assign mag_y = dy_ff[24] ? 25'(-dy_ff) : 25'(dy_ff);

   // rotate by minus the heading; half-turn folded in before the cordic
   assign z_raw   = 32'd0 - {heading_ff, 16'd0};
   assign pre_rot = (z_raw > 32'h4000_0000) && (z_raw < 32'hC000_0000);
   assign sx      = rx_ff >>> rot_i_ff;
   assign sy      = ry_ff >>> rot_i_ff;
   assign ang     = 34'(cordic_angle(rot_i_ff));

   // arm times turn rate, scaled toward zero
   assign lw_prod = signed'({1'b0, arm_sum_ff}) * w_ff;
   assign lw_adj  = 48'(lw_prod) + ((lw_prod < 0) ? 48'sd65535 : 48'sd0);

   assign vx_e = 33'(vx_ff);
   assign vy_e = 33'(vy_ff);
   assign lw_e = 33'(lw_ff);
   always_comb begin
      case (wh_k_ff)
         2'd0:    s_wheel = vx_e - vy_e - lw_e;
         2'd1:    s_wheel = vx_e + vy_e + lw_e;
         2'd2:    s_wheel = vx_e + vy_e - lw_e;
         default: s_wheel = vx_e - vy_e + lw_e;
      endcase
   end

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_op == OP_MANUAL) begin
               state_in = S_WH_LW;
            end else if (accept && req_op == OP_REPORT && fire) begin
               state_in = path_end ? S_OUT : S_SCAN_RD;
            end
         end
         S_SCAN_RD:  state_in = S_SCAN_SQ;
         S_SCAN_SQ:  state_in = S_SCAN_CMP;
         S_SCAN_CMP: state_in = ({1'b0, scan_idx_ff} == n_last) ? S_TGT_RD : S_SCAN_RD;
         S_TGT_RD:   state_in = S_TGT_SQ;
         S_TGT_SQ:   state_in = S_TGT_SUM;
         S_TGT_SUM:  state_in = S_SQRT;
         S_SQRT:     state_in = (sq_k_ff == 5'd0) ? S_DL_SET : S_SQRT;
         S_DL_SET:   state_in = (max_speed_ff == 20'd0) ? S_WH_LW : S_DIV;
         S_DIV:      state_in = (div_cnt_ff == 6'd0) ? ret_ff : S_DIV;
         S_DL_END:   state_in = (sq_res_ff[25:0] == 26'd0) ? S_WH_LW : S_DIV;
         S_VX_END:   state_in = S_DIV;
         S_VY_END:   state_in = S_ROT_INIT;
         S_ROT_INIT: state_in = S_ROT_STEP;
         S_ROT_STEP: state_in = (rot_i_ff == ROT_LAST) ? S_ROT_MX : S_ROT_STEP;
         S_ROT_MX:   state_in = S_ROT_MY;
         S_ROT_MY:   state_in = S_ROT_END;
         S_ROT_END:  state_in = S_WH_LW;
         S_WH_LW:    state_in = S_WH_MUL;
         S_WH_MUL:   state_in = S_WH_CLP;
         S_WH_CLP:   state_in = (wh_k_ff == 2'd3) ? S_OUT : S_WH_MUL;
         S_OUT:      state_in = (!rsp_valid_ff || !rsp_stall) ? S_IDLE : S_OUT;
         default:    state_in = S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         target_slot_ff   <= 7'd0;
         elapsed_ff       <= 32'd0;
         deadline_ff      <= 32'd0;
         timer_running_ff <= 1'b0;
         first_report_ff  <= 1'b1;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         // a new result replaces the one leaving in the same cycle
         if (state_ff == S_OUT && (!rsp_valid_ff || !rsp_stall)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept && req_op == OP_TICK && timer_running_ff &&
                   elapsed_ff != 32'hFFFF_FFFF) begin
                  elapsed_ff <= elapsed_ff + 32'd1;
               end
               if (accept && req_op == OP_REPORT && fire) begin
                  first_report_ff  <= 1'b0;
                  elapsed_ff       <= 32'd0;
                  // end of path stops the timer for good
                  timer_running_ff <= ~path_end;
               end
            end
            S_SCAN_CMP: begin
               if (!found_ff || sq_sum < best_ff) begin
                  target_slot_ff <= next_tgt;
               end
            end
            S_DL_SET: begin
               if (max_speed_ff == 20'd0) begin
                  deadline_ff <= 32'hFFFF_FFFF;
               end
            end
            S_DL_END: begin
               deadline_ff <= (|div_num_ff[47:32]) ? 32'hFFFF_FFFF : div_num_ff[31:0];
            end
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            px_ff       <= req_pos_x;
            py_ff       <= req_pos_y;
            heading_ff  <= req_heading;
            scan_idx_ff <= target_slot_ff;
            found_ff    <= 1'b0;
            // only a report at the end of the path is flagged done
            done_ff     <= (req_op != OP_MANUAL) && path_end;
            for (int k = 0; k < 4; k++) begin
               wres_ff[k] <= '0;
            end
            if (req_op == OP_MANUAL) begin
               vx_ff   <= -26'(req_cmd_vx);
               vy_ff   <= -26'(req_cmd_vy);
               w_ff    <= -26'(req_cmd_turn);
            end
         end
         S_SCAN_SQ, S_TGT_SQ: begin
            sqx_ff <= ex_sq[48:0];
            sqy_ff <= ey_sq[48:0];
            dx_ff  <= ex;
            dy_ff  <= ey;
         end
         S_SCAN_CMP: begin
            if (!found_ff || sq_sum < best_ff) begin
               found_ff <= 1'b1;
               best_ff  <= sq_sum;
            end
            scan_idx_ff <= scan_idx_ff + 7'd1;
         end
         S_TGT_SUM: begin
            sq_rem_ff <= sq_sum;
            sq_res_ff <= '0;
            sq_k_ff   <= 5'd24;
         end
         S_SQRT: begin
            if ({1'b0, sq_rem_ff} >= sq_trial) begin
               sq_rem_ff <= 50'({1'b0, sq_rem_ff} - sq_trial);
               sq_res_ff <= (sq_res_ff >> 1) + sq_bit;
            end else begin
               sq_res_ff <= sq_res_ff >> 1;
            end
            sq_k_ff <= sq_k_ff - 5'd1;
         end
         S_DL_SET: begin
            // travel time in ms
            div_num_ff <= 48'(sq_res_ff[25:0] * MS_PER_S);
            div_den_ff <= {6'd0, max_speed_ff};
            div_rem_ff <= '0;
            div_cnt_ff <= 6'd47;
            ret_ff     <= S_DL_END;
            vx_ff      <= '0;
            vy_ff      <= '0;
            w_ff       <= '0;
         end
         S_DIV: begin
            div_rem_ff <= div_ge ? 26'(div_t - {1'b0, div_den_ff}) : div_t[25:0];
            div_num_ff <= {div_num_ff[46:0], div_ge};
            div_cnt_ff <= div_cnt_ff - 6'd1;
         end
         S_DL_END: begin
            div_num_ff <= 48'(max_speed_ff * mag_x);
            div_den_ff <= sq_res_ff[25:0];
            div_rem_ff <= '0;
            div_cnt_ff <= 6'd47;
            ret_ff     <= S_VX_END;
         end
         S_VX_END: begin
            vx_ff      <= dx_ff[24] ? -26'(div_num_ff[20:0]) : 26'(div_num_ff[20:0]);
            div_num_ff <= 48'(max_speed_ff * mag_y);
            div_rem_ff <= '0;
            div_cnt_ff <= 6'd47;
            ret_ff     <= S_VY_END;
         end
         S_VY_END: begin
            vy_ff <= dy_ff[24] ? -26'(div_num_ff[20:0]) : 26'(div_num_ff[20:0]);
         end
         S_ROT_INIT: begin
            rx_ff    <= pre_rot ? -{vx_ff, 8'd0} : {vx_ff, 8'd0};
            ry_ff    <= pre_rot ? -{vy_ff, 8'd0} : {vy_ff, 8'd0};
            rz_ff    <= 34'(signed'(pre_rot ? z_raw + 32'h8000_0000 : z_raw));
            rot_i_ff <= 5'd0;
         end
         S_ROT_STEP: begin
            if (rz_ff >= 0) begin
               rx_ff <= rx_ff - sy;
               ry_ff <= ry_ff + sx;
               rz_ff <= rz_ff - ang;
            end else begin
               rx_ff <= rx_ff + sy;
               ry_ff <= ry_ff - sx;
               rz_ff <= rz_ff + ang;
            end
            rot_i_ff <= rot_i_ff + 5'd1;
         end
         S_ROT_MX: begin
            // undo the cordic gain, rounding half up
            rprod_ff <= 52'(rx_ff * signed'(CORDIC_COMP)) + 52'sd8388608;
         end
         S_ROT_MY: begin
            vx_ff    <= rprod_ff[49:24];
            rprod_ff <= 52'(ry_ff * signed'(CORDIC_COMP)) + 52'sd8388608;
         end
         S_ROT_END: begin
            vy_ff <= rprod_ff[49:24];
         end
         S_WH_LW: begin
            lw_ff   <= lw_adj[46:16];
            wh_k_ff <= 2'd0;
         end
         S_WH_MUL: begin
            wprod_ff <= s_wheel * signed'({1'b0, wheel_gain_ff});
         end
         S_WH_CLP: begin
            wres_ff[wh_k_ff] <= wheel_clamp(wprod_ff, max_wheel_rpm_ff);
            wh_k_ff          <= wh_k_ff + 2'd1;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               for (int k = 0; k < 4; k++) begin
                  rsp_wheel_ff[k] <= wres_ff[k];
               end
               rsp_target_ff <= target_slot_ff;
               rsp_done_ff   <= done_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_wheel_one    = rsp_wheel_ff[0];
   assign rsp_wheel_two    = rsp_wheel_ff[1];
   assign rsp_wheel_three  = rsp_wheel_ff[2];
   assign rsp_wheel_four   = rsp_wheel_ff[3];
   assign rsp_target_index = rsp_target_ff;
   assign rsp_path_done    = rsp_done_ff;

   // ---------------------------------------------------------------- checks
   `MWF_ASSERT_IMP(a_scan_in_range, clock, reset, state_ff == S_SCAN_RD, 8'(scan_idx_ff) < n_eff)
   `MWF_ASSERT_IMP(a_done_wheels_zero, clock, reset, rsp_valid_ff && rsp_done_ff, rsp_wheel_ff[0] == 16'sd0 && rsp_wheel_ff[3] == 16'sd0)
   `MWF_ASSERT_IMP(a_done_timer_off, clock, reset, rsp_valid_ff && rsp_done_ff, !timer_running_ff)
   `MWF_ASSERT_NXT(a_manual_to_wheels, clock, reset, state_ff == S_IDLE && accept && req_op == OP_MANUAL, state_ff == S_WH_LW)

endmodule
